// ----- hdl/trs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trs_pkg
// Field widths and saturation limits shared by the TRS matrix pipeline.
// ----------------------------------------------------------------------------
package trs_pkg;

    localparam int SCALE_W = 16;
    localparam int POS_W   = 24;
    localparam int QUAT_W  = 16;
    localparam int ENTRY_W = 16;

    localparam int ENTRY_MAX = 32767;
    localparam int ENTRY_MIN = -32768;

    typedef logic signed [SCALE_W-1:0] t_scale;
    typedef logic signed [POS_W-1:0]   t_pos;
    typedef logic signed [QUAT_W-1:0]  t_quat;
    typedef logic signed [ENTRY_W-1:0] t_entry;

endpackage

// ----- hdl/trs_scale_sat.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trs_scale_sat
// Two-stage entry scaler: rotation entry times scale, then round to nearest
// (ties away from zero), drop the entry fraction bits and saturate to Q8.8.
// ----------------------------------------------------------------------------
module trs_scale_sat #(
    parameter int ENT_W = 35,
    parameter int SHIFT = 28
) (
    input  logic            i_clk,
    input  logic signed [ENT_W-1:0] i_ent,
    input  trs_pkg::t_scale i_scale,
    output trs_pkg::t_entry o_entry
);
    import trs_pkg::*;

    localparam int PW = ENT_W + SCALE_W;
    localparam int RW = PW + 1 - SHIFT;
    localparam logic [PW-1:0] HALF_V = PW'(1) << (SHIFT - 1);
    localparam logic signed [RW-1:0] Q_MAX = RW'(ENTRY_MAX);
    localparam logic signed [RW-1:0] Q_MIN = RW'(ENTRY_MIN);

    logic signed [PW-1:0] r_prod;
    logic signed [PW:0]   n_sum;
    logic signed [RW-1:0] n_q;
    t_entry               n_entry;
    t_entry               r_entry;

    always_ff @(posedge i_clk) begin
        r_prod <= PW'(i_ent) * PW'(i_scale);
    end

    // negative values take one off the half so ties round away from zero
    always_comb begin
        n_sum = $signed({r_prod[PW-1], r_prod}) + $signed({1'b0, HALF_V})
              - $signed({{PW{1'b0}}, r_prod[PW-1]});
        n_q   = RW'(n_sum >>> SHIFT);
        if (n_q > Q_MAX) begin
            n_entry = ENTRY_W'(ENTRY_MAX);
        end else if (n_q < Q_MIN) begin
            n_entry = ENTRY_W'(ENTRY_MIN);
        end else begin
            n_entry = ENTRY_W'(n_q);
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ----- hdl/trs_matrix_from_quaternion_top.sv -----
`timescale 1ns / 1ps
// throughput: one beat per cycle, set by the four-stage multiply pipeline
// busy is low except while reset is held; the receiver cannot stall
// reset: synchronous active-low, clears the valid line only
// ----------------------------------------------------------------------------
// trs_matrix_from_quaternion_top
// TRS model matrix from scale, position and unit quaternion: quaternion
// products, rotation entries, scaling, then rounding and saturation.
// ----------------------------------------------------------------------------
module trs_matrix_from_quaternion_top #(
    parameter int QUAT_FRAC_BITS = 14
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  trs_pkg::t_scale i_scale_x,
    input  trs_pkg::t_scale i_scale_y,
    input  trs_pkg::t_scale i_scale_z,
    input  trs_pkg::t_pos   i_pos_x,
    input  trs_pkg::t_pos   i_pos_y,
    input  trs_pkg::t_pos   i_pos_z,
    input  trs_pkg::t_quat  i_quat_w,
    input  trs_pkg::t_quat  i_quat_x,
    input  trs_pkg::t_quat  i_quat_y,
    input  trs_pkg::t_quat  i_quat_z,
    output logic            o_strobe,
    output trs_pkg::t_entry o_m_c0_r0,
    output trs_pkg::t_entry o_m_c0_r1,
    output trs_pkg::t_entry o_m_c0_r2,
    output trs_pkg::t_entry o_m_c1_r0,
    output trs_pkg::t_entry o_m_c1_r1,
    output trs_pkg::t_entry o_m_c1_r2,
    output trs_pkg::t_entry o_m_c2_r0,
    output trs_pkg::t_entry o_m_c2_r1,
    output trs_pkg::t_entry o_m_c2_r2,
    output trs_pkg::t_pos   o_trans_x,
    output trs_pkg::t_pos   o_trans_y,
    output trs_pkg::t_pos   o_trans_z
);
    import trs_pkg::*;

    localparam int SHIFT = 2 * QUAT_FRAC_BITS;
    localparam int PRD_W = 2 * QUAT_W;
    localparam int EW    = (SHIFT + 3 > 35) ? SHIFT + 3 : 35;
    localparam logic [EW-1:0] ONE_V = EW'(1) << SHIFT;
    localparam int STAGES = 4;

    logic [STAGES-1:0] r_vld;
    logic              n_accept;

    logic signed [PRD_W-1:0] r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    t_scale r_sc1 [3];
    t_scale r_sc2 [3];
    t_pos   r_pos [STAGES][3];

    logic signed [EW-1:0] n_ent [9];
    logic signed [EW-1:0] r_ent [9];
    t_entry               w_out [9];

    assign busy     = ~i_rst_n;
    assign n_accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[STAGES-2:0], n_accept};
        end
    end

    // stage 1: quaternion products
    always_ff @(posedge i_clk) begin
        r_xx <= PRD_W'(i_quat_x) * PRD_W'(i_quat_x);
        r_yy <= PRD_W'(i_quat_y) * PRD_W'(i_quat_y);
        r_zz <= PRD_W'(i_quat_z) * PRD_W'(i_quat_z);
        r_xy <= PRD_W'(i_quat_x) * PRD_W'(i_quat_y);
        r_xz <= PRD_W'(i_quat_x) * PRD_W'(i_quat_z);
        r_yz <= PRD_W'(i_quat_y) * PRD_W'(i_quat_z);
        r_wx <= PRD_W'(i_quat_w) * PRD_W'(i_quat_x);
        r_wy <= PRD_W'(i_quat_w) * PRD_W'(i_quat_y);
        r_wz <= PRD_W'(i_quat_w) * PRD_W'(i_quat_z);
        r_sc1[0] <= i_scale_x;
        r_sc1[1] <= i_scale_y;
        r_sc1[2] <= i_scale_z;
        r_pos[0][0] <= i_pos_x;
        r_pos[0][1] <= i_pos_y;
        r_pos[0][2] <= i_pos_z;
        for (int s = 1; s < STAGES; s++) begin
            r_pos[s] <= r_pos[s-1];
        end
    end

    // stage 2: rotation entries, column-major
    always_comb begin
        n_ent[0] = $signed(ONE_V) - ((EW'(r_yy) + EW'(r_zz)) <<< 1);
        n_ent[1] = (EW'(r_xy) + EW'(r_wz)) <<< 1;
        n_ent[2] = (EW'(r_xz) - EW'(r_wy)) <<< 1;
        n_ent[3] = (EW'(r_xy) - EW'(r_wz)) <<< 1;
        n_ent[4] = $signed(ONE_V) - ((EW'(r_xx) + EW'(r_zz)) <<< 1);
        n_ent[5] = (EW'(r_yz) + EW'(r_wx)) <<< 1;
        n_ent[6] = (EW'(r_xz) + EW'(r_wy)) <<< 1;
        n_ent[7] = (EW'(r_yz) - EW'(r_wx)) <<< 1;
        n_ent[8] = $signed(ONE_V) - ((EW'(r_xx) + EW'(r_yy)) <<< 1);
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
        r_sc2 <= r_sc1;
    end

    // stages 3 and 4: scale, round, saturate
    for (genvar g = 0; g < 9; g++) begin : g_ent
        trs_scale_sat #(
            .ENT_W (EW),
            .SHIFT (SHIFT)
        ) u_scale_sat (
            .i_clk   (i_clk),
            .i_ent   (r_ent[g]),
            .i_scale (r_sc2[g / 3]),
            .o_entry (w_out[g])
        );
    end

    assign o_strobe  = r_vld[STAGES-1];
    assign o_m_c0_r0 = w_out[0];
    assign o_m_c0_r1 = w_out[1];
    assign o_m_c0_r2 = w_out[2];
    assign o_m_c1_r0 = w_out[3];
    assign o_m_c1_r1 = w_out[4];
    assign o_m_c1_r2 = w_out[5];
    assign o_m_c2_r0 = w_out[6];
    assign o_m_c2_r1 = w_out[7];
    assign o_m_c2_r2 = w_out[8];
    assign o_trans_x = r_pos[STAGES-1][0];
    assign o_trans_y = r_pos[STAGES-1][1];
    assign o_trans_z = r_pos[STAGES-1][2];

endmodule

// ----- verif/tb_trs_matrix_from_quaternion_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trs_matrix_from_quaternion_top
// Self-checking bench for the TRS matrix pipeline. A directed set covers
// identity and axis rotations, non-unit and extreme quaternions, saturation
// and rounding ties; random beats then mix normalized rotations with raw
// full-range fields. Every accepted beat is predicted in the bench and each
// strobed matrix is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_trs_matrix_from_quaternion_top;

    import trs_pkg::*;

    localparam int QUAT_FRAC    = 14;
    localparam int RANDOM_BEATS = 1400;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PRINT_LIMIT  = 40;

    typedef struct {
        t_scale scale_x, scale_y, scale_z;
        t_pos   pos_x, pos_y, pos_z;
        t_quat  quat_w, quat_x, quat_y, quat_z;
    } t_pose_beat;

    typedef struct {
        t_entry c0_r0, c0_r1, c0_r2;
        t_entry c1_r0, c1_r1, c1_r2;
        t_entry c2_r0, c2_r1, c2_r2;
        t_pos   trans_x, trans_y, trans_z;
    } t_matrix_beat;

    logic   i_clk;
    logic   i_rst_n;
    logic   start;
    logic   busy;
    t_scale i_scale_x, i_scale_y, i_scale_z;
    t_pos   i_pos_x, i_pos_y, i_pos_z;
    t_quat  i_quat_w, i_quat_x, i_quat_y, i_quat_z;
    logic   o_strobe;
    t_entry o_m_c0_r0, o_m_c0_r1, o_m_c0_r2;
    t_entry o_m_c1_r0, o_m_c1_r1, o_m_c1_r2;
    t_entry o_m_c2_r0, o_m_c2_r1, o_m_c2_r2;
    t_pos   o_trans_x, o_trans_y, o_trans_z;

    t_pose_beat   pose_q[$];
    t_matrix_beat matrix_q[$];
    t_pose_beat   pose_cur;
    int           pose_total;
    int           pose_sent;
    int           mismatch_count;
    int           cycle_count;

    trs_matrix_from_quaternion_top #(
        .QUAT_FRAC_BITS(QUAT_FRAC)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_scale_x(i_scale_x),
        .i_scale_y(i_scale_y),
        .i_scale_z(i_scale_z),
        .i_pos_x  (i_pos_x),
        .i_pos_y  (i_pos_y),
        .i_pos_z  (i_pos_z),
        .i_quat_w (i_quat_w),
        .i_quat_x (i_quat_x),
        .i_quat_y (i_quat_y),
        .i_quat_z (i_quat_z),
        .o_strobe (o_strobe),
        .o_m_c0_r0(o_m_c0_r0),
        .o_m_c0_r1(o_m_c0_r1),
        .o_m_c0_r2(o_m_c0_r2),
        .o_m_c1_r0(o_m_c1_r0),
        .o_m_c1_r1(o_m_c1_r1),
        .o_m_c1_r2(o_m_c1_r2),
        .o_m_c2_r0(o_m_c2_r0),
        .o_m_c2_r1(o_m_c2_r1),
        .o_m_c2_r2(o_m_c2_r2),
        .o_trans_x(o_trans_x),
        .o_trans_y(o_trans_y),
        .o_trans_z(o_trans_z)
    );

    always #10 i_clk = ~i_clk;

    // rotation entry times scale, rounded half away from zero, saturated
    function automatic t_entry scaled_entry(longint rot, longint scl);
        longint prod;
        longint mag;
        longint q;
        prod = rot * scl;
        mag  = (prod < 0) ? -prod : prod;
        q    = (mag + (64'sd1 <<< (2 * QUAT_FRAC - 1))) >>> (2 * QUAT_FRAC);
        if (prod < 0) begin
            q = (q > 32768) ? longint'(ENTRY_MIN) : -q;
        end else begin
            q = (q > 32767) ? longint'(ENTRY_MAX) : q;
        end
        return t_entry'(q[ENTRY_W-1:0]);
    endfunction

    function automatic t_matrix_beat trs_matrix_of(t_pose_beat p);
        t_matrix_beat m;
        longint w, x, y, z, unit;
        longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
        longint sx, sy, sz;
        w  = p.quat_w;
        x  = p.quat_x;
        y  = p.quat_y;
        z  = p.quat_z;
        sx = p.scale_x;
        sy = p.scale_y;
        sz = p.scale_z;
        unit = 64'sd1 <<< (2 * QUAT_FRAC);
        xx = x * x;
        yy = y * y;
        zz = z * z;
        xy = x * y;
        xz = x * z;
        yz = y * z;
        wx = w * x;
        wy = w * y;
        wz = w * z;
        m.c0_r0 = scaled_entry(unit - 2 * (yy + zz), sx);
        m.c0_r1 = scaled_entry(2 * (xy + wz), sx);
        m.c0_r2 = scaled_entry(2 * (xz - wy), sx);
        m.c1_r0 = scaled_entry(2 * (xy - wz), sy);
        m.c1_r1 = scaled_entry(unit - 2 * (xx + zz), sy);
        m.c1_r2 = scaled_entry(2 * (yz + wx), sy);
        m.c2_r0 = scaled_entry(2 * (xz + wy), sz);
        m.c2_r1 = scaled_entry(2 * (yz - wx), sz);
        m.c2_r2 = scaled_entry(unit - 2 * (xx + yy), sz);
        m.trans_x = p.pos_x;
        m.trans_y = p.pos_y;
        m.trans_z = p.pos_z;
        return m;
    endfunction

    function automatic t_pose_beat pose_of(int sx, int sy, int sz, int px, int py, int pz,
                                           int w, int x, int y, int z);
        t_pose_beat p;
        p.scale_x = t_scale'(sx);
        p.scale_y = t_scale'(sy);
        p.scale_z = t_scale'(sz);
        p.pos_x   = t_pos'(px);
        p.pos_y   = t_pos'(py);
        p.pos_z   = t_pos'(pz);
        p.quat_w  = t_quat'(w);
        p.quat_x  = t_quat'(x);
        p.quat_y  = t_quat'(y);
        p.quat_z  = t_quat'(z);
        return p;
    endfunction

    function automatic int random_scale();
        if ($urandom_range(99) < 30) begin
            return int'($signed(16'($urandom)));
        end
        return int'($urandom_range(2048)) - 1024;
    endfunction

    function automatic t_pose_beat random_pose();
        t_pose_beat p;
        real a, b, c, d, n;
        int  kind;
        p = pose_of(random_scale(), random_scale(), random_scale(),
                    int'($urandom), int'($urandom), int'($urandom), 0, 0, 0, 0);
        kind = $urandom_range(99);
        if (kind < 60) begin
            // normalized rotation
            a = (real'($urandom_range(2000)) - 1000.0) / 1000.0;
            b = (real'($urandom_range(2000)) - 1000.0) / 1000.0;
            c = (real'($urandom_range(2000)) - 1000.0) / 1000.0;
            d = (real'($urandom_range(2000)) - 1000.0) / 1000.0;
            n = $sqrt(a * a + b * b + c * c + d * d);
            if (n < 0.001) begin
                a = 1.0;
                n = 1.0;
            end
            p.quat_w = t_quat'($rtoi(a / n * 16384.0));
            p.quat_x = t_quat'($rtoi(b / n * 16384.0));
            p.quat_y = t_quat'($rtoi(c / n * 16384.0));
            p.quat_z = t_quat'($rtoi(d / n * 16384.0));
        end else if (kind < 80) begin
            p.quat_w = t_quat'(int'($urandom_range(32768)) - 16384);
            p.quat_x = t_quat'(int'($urandom_range(32768)) - 16384);
            p.quat_y = t_quat'(int'($urandom_range(32768)) - 16384);
            p.quat_z = t_quat'(int'($urandom_range(32768)) - 16384);
        end else begin
            p.quat_w = t_quat'($urandom);
            p.quat_x = t_quat'($urandom);
            p.quat_y = t_quat'($urandom);
            p.quat_z = t_quat'($urandom);
        end
        return p;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("%0t: %s got %0d expected %0d", $realtime, field, got, want);
        end
        mismatch_count++;
    endtask

    task automatic check_field(string field, longint got, longint want);
        if (got != want) begin
            report_mismatch(field, got, want);
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                matrix_q.push_back(trs_matrix_of(pose_cur));
                pose_sent++;
            end
            if (!start || !busy) begin
                if (pose_q.size() > 0 &&
                    ((pose_sent >= 500 && pose_sent < 800) || $urandom_range(99) >= 17)) begin
                    pose_cur  = pose_q.pop_front();
                    i_scale_x <= pose_cur.scale_x;
                    i_scale_y <= pose_cur.scale_y;
                    i_scale_z <= pose_cur.scale_z;
                    i_pos_x   <= pose_cur.pos_x;
                    i_pos_y   <= pose_cur.pos_y;
                    i_pos_z   <= pose_cur.pos_z;
                    i_quat_w  <= pose_cur.quat_w;
                    i_quat_x  <= pose_cur.quat_x;
                    i_quat_y  <= pose_cur.quat_y;
                    i_quat_z  <= pose_cur.quat_z;
                    start     <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_matrix_beat want;
        if (i_rst_n && o_strobe) begin
            if (matrix_q.size() == 0) begin
                report_mismatch("unexpected beat, strobe", 1, 0);
            end else begin
                want = matrix_q.pop_front();
                check_field("m_c0_r0", o_m_c0_r0, want.c0_r0);
                check_field("m_c0_r1", o_m_c0_r1, want.c0_r1);
                check_field("m_c0_r2", o_m_c0_r2, want.c0_r2);
                check_field("m_c1_r0", o_m_c1_r0, want.c1_r0);
                check_field("m_c1_r1", o_m_c1_r1, want.c1_r1);
                check_field("m_c1_r2", o_m_c1_r2, want.c1_r2);
                check_field("m_c2_r0", o_m_c2_r0, want.c2_r0);
                check_field("m_c2_r1", o_m_c2_r1, want.c2_r1);
                check_field("m_c2_r2", o_m_c2_r2, want.c2_r2);
                check_field("trans_x", o_trans_x, want.trans_x);
                check_field("trans_y", o_trans_y, want.trans_y);
                check_field("trans_z", o_trans_z, want.trans_z);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_scale_x      = '0;
        i_scale_y      = '0;
        i_scale_z      = '0;
        i_pos_x        = '0;
        i_pos_y        = '0;
        i_pos_z        = '0;
        i_quat_w       = '0;
        i_quat_x       = '0;
        i_quat_y       = '0;
        i_quat_z       = '0;
        pose_sent      = 0;
        mismatch_count = 0;
        cycle_count    = 0;

        // identity, axis half turns and a quarter turn
        pose_q.push_back(pose_of(256, 256, 256, 0, 0, 0, 16384, 0, 0, 0));
        pose_q.push_back(pose_of(32767, -32768, 0, 8388607, -8388608, 0, 16384, 0, 0, 0));
        pose_q.push_back(pose_of(256, 512, -256, 1, -1, 256, -16384, 0, 0, 0));
        pose_q.push_back(pose_of(256, 256, 256, -1, 100, -100, 11585, 0, 0, 11585));
        pose_q.push_back(pose_of(384, 256, 128, 0, 0, 0, 0, 16384, 0, 0));
        pose_q.push_back(pose_of(256, -384, 256, 0, 0, 0, 0, 0, 16384, 0));
        pose_q.push_back(pose_of(256, 256, 32767, 0, 0, 0, 0, 0, 0, 16384));
        pose_q.push_back(pose_of(256, 256, 256, 0, 0, 0, 0, -16384, -16384, -16384));
        // non-unit quaternions, saturation both ways
        pose_q.push_back(pose_of(32767, 32767, 32767, 0, 0, 0, -32768, -32768, -32768, -32768));
        pose_q.push_back(pose_of(-32768, -32768, -32768, 0, 0, 0, 16384, 16384, 16384, 16384));
        pose_q.push_back(pose_of(32767, -32768, 1, 0, 0, 0, -32768, 16384, -16384, 0));
        pose_q.push_back(pose_of(-1, 1, -32768, 0, 0, 0, 32767, 32767, 32767, 32767));
        pose_q.push_back(pose_of(256, 256, 256, 0, 0, 0, 0, 0, 0, 0));
        // exact rounding ties, positive and negative
        pose_q.push_back(pose_of(2048, 2048, -2048, 5, 6, 7, 0, 128, 256, 0));
        pose_q.push_back(pose_of(-2048, -2048, 2048, 0, 0, 0, 0, 128, 256, 0));
        pose_q.push_back(pose_of(6144, 2048, 2048, 0, 0, 0, 0, 128, 256, 128));
        // bit patterns on every field
        pose_q.push_back(pose_of('h5555, 'haaaa, 'h5555, 'haaaaaa, 'h555555, 'haaaaaa,
                                 'h5555, 'haaaa, 'h5555, 'haaaa));
        pose_q.push_back(pose_of('haaaa, 'h5555, 'haaaa, 'h555555, 'haaaaaa, 'h555555,
                                 'haaaa, 'h5555, 'haaaa, 'h5555));
        pose_q.push_back(pose_of(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
        pose_q.push_back(pose_of(1, 1, 1, 8388607, 8388607, -8388608, 1, 1, 1, 1));
        for (int k = 0; k < RANDOM_BEATS; k++) begin
            pose_q.push_back(random_pose());
        end
        pose_total = pose_q.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pose_sent < pose_total || matrix_q.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (12) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
